// ----- src/pgs_pkg.sv -----
// Package for the power good supervisor: codes, thresholds, field widths and
// the status struct passed from the power evaluator to the top level.
// No dependencies.
package pgs_pkg;

  // Field widths
  localparam int unsigned MvW     = 14;  // signed millivolt fields
  localparam int unsigned RawW    = 11;  // signed raw ADC field
  localparam int unsigned FlagW   = 2;   // signed tri-state flags
  localparam int unsigned RegW    = 13;  // threshold registers
  localparam int unsigned CfgIdxW = 1;   // two registers

  localparam int unsigned InDataW  = 64; // 60 payload bits, byte padded
  localparam int unsigned OutDataW = 8;  // 7 payload bits, byte padded

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_BATTERY_MIN = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_RAIL_MIN    = 1'd1;

  localparam logic [RegW-1:0] BATTERY_MIN_RESET = 13'd3300;
  localparam logic [RegW-1:0] RAIL_MIN_RESET    = 13'd4500;

  // Operation codes (travel on tuser)
  localparam logic OP_REFRESH = 1'b0;
  localparam logic OP_BUTTON  = 1'b1;

  // Rail clamp and battery mapping constants
  localparam logic [RegW-1:0] RAIL_CLAMP_MV = 13'd5500;
  localparam logic [9:0]      RAW_CLAMP     = 10'd930;
  localparam logic [RegW-1:0] BATT_LOW_MV   = 13'd3000;
  localparam logic [RegW-1:0] BATT_HIGH_MV  = 13'd4200;

  // (raw*1200 + 465) / 930 == (40*raw + 15) / 31 for raw <= 930.
  // Divide by 31 as multiply by ceil(2^21/31), exact for numerators < 72315.
  localparam logic [15:0] MAP_OFFSET = 16'd15;
  localparam int unsigned RecipShift = 21;
  localparam logic [16:0] RECIP_31   = 17'd67651;

  typedef enum logic [1:0] {
    SRC_NONE     = 2'd0,
    SRC_COMPUTER = 2'd1,
    SRC_CHARGER  = 2'd2,
    SRC_OTG      = 2'd3
  } usb_source_t;

  typedef struct packed {
    logic        has_power;
    usb_source_t usb_source;
  } power_status_t;

endpackage

// ----- src/pgs_batt_level.sv -----
// Battery voltage selection: direct millivolts, else mapped raw ADC level,
// else the full-charge default. Depends on pgs_pkg.
module pgs_batt_level (
  input  logic signed [pgs_pkg::MvW-1:0]  battery_mv,
  input  logic signed [pgs_pkg::RawW-1:0] battery_raw,
  output logic        [pgs_pkg::RegW-1:0] level_mv
);

  logic [9:0]  raw_clamped;
  logic [15:0] numer;
  logic [32:0] prod;
  logic [10:0] quot;

  always_comb begin
    raw_clamped = (battery_raw[9:0] > pgs_pkg::RAW_CLAMP) ? pgs_pkg::RAW_CLAMP
                                                           : battery_raw[9:0];
    // 40*r + 15 with shifts
    numer = {1'b0, raw_clamped, 5'b0} + {3'b0, raw_clamped, 3'b0} + pgs_pkg::MAP_OFFSET;
    prod  = 33'(numer) * 33'(pgs_pkg::RECIP_31);
    quot  = prod[pgs_pkg::RecipShift +: 11];
  end

  always_comb begin
    if (!battery_mv[pgs_pkg::MvW-1]) begin
      level_mv = battery_mv[pgs_pkg::RegW-1:0];
    end else if (!battery_raw[pgs_pkg::RawW-1]) begin
      level_mv = pgs_pkg::BATT_LOW_MV + {2'b0, quot};
    end else begin
      level_mv = pgs_pkg::BATT_HIGH_MV;
    end
  end

endmodule

// ----- src/pgs_power_eval.sv -----
// Source classification and power decision for one beat.
// Depends on pgs_pkg and pgs_batt_level.
module pgs_power_eval (
  input  logic                              otg_cable,
  input  logic                              cable_connected,
  input  logic signed [pgs_pkg::MvW-1:0]    bus_mv,
  input  logic                              host_link_active,
  input  logic signed [pgs_pkg::FlagW-1:0]  dock_attached,
  input  logic signed [pgs_pkg::MvW-1:0]    dock_rail_mv,
  input  logic signed [pgs_pkg::FlagW-1:0]  battery_present,
  input  logic signed [pgs_pkg::MvW-1:0]    battery_mv,
  input  logic signed [pgs_pkg::RawW-1:0]   battery_raw,
  input  logic        [pgs_pkg::RegW-1:0]   battery_min_mv,
  input  logic        [pgs_pkg::RegW-1:0]   rail_min_mv,
  output pgs_pkg::power_status_t            status
);

  logic [pgs_pkg::RegW-1:0] batt_level;
  logic [pgs_pkg::RegW-1:0] bus_clamped;
  logic [pgs_pkg::RegW-1:0] dock_clamped;
  logic                     bus_low;
  logic                     ext_ok;
  logic                     batt_ok;
  pgs_pkg::usb_source_t     src;

  pgs_batt_level u_batt (
    .battery_mv  (battery_mv),
    .battery_raw (battery_raw),
    .level_mv    (batt_level)
  );

  function automatic logic [pgs_pkg::RegW-1:0] clamp_rail(
    input logic signed [pgs_pkg::MvW-1:0] v
  );
    logic [pgs_pkg::RegW-1:0] r;
    if (v[pgs_pkg::MvW-1]) begin
      r = '0;
    end else if (v[pgs_pkg::RegW-1:0] > pgs_pkg::RAIL_CLAMP_MV) begin
      r = pgs_pkg::RAIL_CLAMP_MV;
    end else begin
      r = v[pgs_pkg::RegW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    // unclamped signed compare; a missing reading is below any threshold
    bus_low = $signed({bus_mv[pgs_pkg::MvW-1], bus_mv}) < $signed({2'b00, rail_min_mv});

    if (otg_cable) begin
      src = pgs_pkg::SRC_OTG;
    end else if (!cable_connected || bus_low) begin
      src = pgs_pkg::SRC_NONE;
    end else if (host_link_active) begin
      src = pgs_pkg::SRC_COMPUTER;
    end else begin
      src = pgs_pkg::SRC_CHARGER;
    end

    bus_clamped  = clamp_rail(bus_mv);
    dock_clamped = clamp_rail(dock_rail_mv);

    ext_ok = ((src == pgs_pkg::SRC_COMPUTER || src == pgs_pkg::SRC_CHARGER)
              && bus_clamped >= rail_min_mv)
          || (dock_attached == 2'sb01 && dock_clamped >= rail_min_mv);
    batt_ok = (battery_present != '0) && (batt_level >= battery_min_mv);

    status.has_power  = ext_ok || batt_ok;
    status.usb_source = src;
  end

endmodule

// ----- src/power_good_supervisor.sv -----
// Power good supervisor (uses pgs_pkg, pgs_power_eval): classifies the USB source,
// decides whether power is good and tracks loss and return of power for sleep and resets.
// An accepted input beat goes through the input register, then the result register, to m_*.
// Throughput: one beat per cycle through the input and result registers; the input
// stalls only while a full result register sees m_tready low.
// Reset (rst, synchronous): thresholds 3300/4500 mV, power history clear, pipe empty.
module power_good_supervisor (
  input  logic                             clk,
  input  logic                             rst,

  // tdata, lowest bit up: otg_cable, cable_connected, bus_mv[14],
  // host_link_active, dock_attached[2], dock_rail_mv[14], battery_present[2],
  // battery_mv[14], battery_raw[11], zero fill
  input  logic [pgs_pkg::InDataW-1:0]      s_tdata,
  // tuser: operation (0 refresh, 1 back reset button)
  input  logic                             s_tuser,
  input  logic                             s_tvalid,
  output logic                             s_tready,

  // tdata, lowest bit up: has_power, usb_source[2], sleep_set, sleep_clear,
  // reset_request, forced_off, zero fill
  output logic [pgs_pkg::OutDataW-1:0]     m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,

  input  logic                             cfg_we,
  input  logic [pgs_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [pgs_pkg::RegW-1:0]         cfg_wdata
);

  // Threshold registers
  logic [pgs_pkg::RegW-1:0] battery_min_mv;
  logic [pgs_pkg::RegW-1:0] rail_min_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_min_mv <= pgs_pkg::BATTERY_MIN_RESET;
      rail_min_mv    <= pgs_pkg::RAIL_MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pgs_pkg::REG_BATTERY_MIN: battery_min_mv <= cfg_wdata;
        pgs_pkg::REG_RAIL_MIN:    rail_min_mv    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1: input register
  logic                        in_valid;
  logic [pgs_pkg::InDataW-1:0] in_data;
  logic                        in_op;
  logic                        advance;

  // stage 1 moves into the result register when that is empty or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_op   <= s_tuser;
    end
  end

  // Power evaluation on the registered beat
  pgs_pkg::power_status_t status;

  pgs_power_eval u_eval (
    .otg_cable        (in_data[0]),
    .cable_connected  (in_data[1]),
    .bus_mv           (in_data[15:2]),
    .host_link_active (in_data[16]),
    .dock_attached    (in_data[18:17]),
    .dock_rail_mv     (in_data[32:19]),
    .battery_present  (in_data[34:33]),
    .battery_mv       (in_data[48:35]),
    .battery_raw      (in_data[59:49]),
    .battery_min_mv   (battery_min_mv),
    .rail_min_mv      (rail_min_mv),
    .status           (status)
  );

  // Power history; updated as each beat leaves stage 1, so the next beat in
  // stage 1 always sees the history left by the previous one.
  logic seen_first, seen_first_next;
  logic last_power, last_power_next;
  logic forced_off, forced_off_next;
  logic sleep_set, sleep_clear, reset_request;

  always_comb begin
    seen_first_next = seen_first;
    last_power_next = last_power;
    forced_off_next = forced_off;
    sleep_set       = 1'b0;
    sleep_clear     = 1'b0;
    reset_request   = 1'b0;
    if (in_op == pgs_pkg::OP_BUTTON) begin
      // button press: reset only with power, history untouched
      reset_request = status.has_power;
    end else if (!seen_first) begin
      // first refresh only records the state (sleep on no power)
      seen_first_next = 1'b1;
      last_power_next = status.has_power;
      if (!status.has_power) begin
        forced_off_next = 1'b1;
        sleep_set       = 1'b1;
      end
    end else begin
      if (!status.has_power) begin
        forced_off_next = 1'b1;
        sleep_set       = 1'b1;
      end else if (!last_power || forced_off) begin
        // power came back
        forced_off_next = 1'b0;
        sleep_clear     = 1'b1;
        reset_request   = 1'b1;
      end
      last_power_next = status.has_power;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first <= 1'b0;
      last_power <= 1'b0;
      forced_off <= 1'b0;
    end else if (advance) begin
      seen_first <= seen_first_next;
      last_power <= last_power_next;
      forced_off <= forced_off_next;
    end
  end

  // Stage 2: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, forced_off_next, reset_request, sleep_clear, sleep_set,
                  status.usb_source, status.has_power};
    end
  end

  // Checks
  a_sleep_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
    else $error("sleep set and clear in one result");

  a_clear_implies_reset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[5] && m_tdata[0])
    else $error("sleep clear without power and reset");

  a_sleep_forces_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[6] && !m_tdata[0])
    else $error("sleep request without forced off");

  a_stall_holds_stage1: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_data))
    else $error("stage 1 beat lost while stalled");

endmodule

// ----- verif/pgs_checker.sv -----
// Checker for the power good supervisor: watches the input, result and config
// ports, predicts each status beat and compares it with what comes out.
// Depends on pgs_pkg.
`timescale 1ns / 1ps

module pgs_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pgs_pkg::InDataW-1:0] s_tdata,
  input  logic                        s_tuser,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [pgs_pkg::OutDataW-1:0] m_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic                        cfg_we,
  input  logic [pgs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pgs_pkg::RegW-1:0]    cfg_wdata,
  output int                          fail_count,
  output int                          pending
);
  import pgs_pkg::*;

  localparam int RawHalf   = 465;
  localparam int ReportMax = 10;

  // Result beat, lowest bit last
  typedef struct packed {
    logic        forced_off;
    logic        reset_request;
    logic        sleep_clear;
    logic        sleep_set;
    usb_source_t usb_source;
    logic        has_power;
  } status_beat_t;

  logic [RegW-1:0] batt_min;
  logic [RegW-1:0] rail_min;
  logic            seen_refresh;
  logic            prev_power;
  logic            forced_flag;
  status_beat_t    status_q[$];
  int              n_bad;

  assign fail_count = n_bad;

  function automatic int clamp_rail(int v);
    if (v < 0) return 0;
    if (v > int'(RAIL_CLAMP_MV)) return int'(RAIL_CLAMP_MV);
    return v;
  endfunction

  // Expected status for one input beat; advances the power tracking state.
  function automatic status_beat_t predict_status(input logic [InDataW-1:0] d,
                                                  input logic op);
    status_beat_t r;
    int   bus, dock, dock_rail, bpres, bmv, braw, rmin, level, raw_c;
    logic ext, power;
    bus       = $signed(d[15:2]);
    dock      = $signed(d[18:17]);
    dock_rail = $signed(d[32:19]);
    bpres     = $signed(d[34:33]);
    bmv       = $signed(d[48:35]);
    braw      = $signed(d[59:49]);
    rmin      = int'(rail_min);
    r = '0;

    // source test uses the raw bus reading, not the clamped one
    if (d[0])                   r.usb_source = SRC_OTG;
    else if (!d[1] || bus < rmin) r.usb_source = SRC_NONE;
    else if (d[16])             r.usb_source = SRC_COMPUTER;
    else                        r.usb_source = SRC_CHARGER;

    ext = ((r.usb_source == SRC_COMPUTER || r.usb_source == SRC_CHARGER)
           && clamp_rail(bus) >= rmin)
       || (dock > 0 && clamp_rail(dock_rail) >= rmin);

    if (bmv >= 0) begin
      level = bmv;
    end else if (braw >= 0) begin
      raw_c = (braw > int'(RAW_CLAMP)) ? int'(RAW_CLAMP) : braw;
      level = int'(BATT_LOW_MV)
            + (raw_c * (int'(BATT_HIGH_MV) - int'(BATT_LOW_MV)) + RawHalf)
              / int'(RAW_CLAMP);
    end else begin
      level = int'(BATT_HIGH_MV);
    end

    power = ext || (bpres != 0 && level >= int'(batt_min));
    r.has_power = power;

    if (op == OP_BUTTON) begin
      r.reset_request = power;
    end else if (!seen_refresh) begin
      seen_refresh = 1'b1;
      prev_power   = power;
      if (!power) begin
        forced_flag = 1'b1;
        r.sleep_set = 1'b1;
      end
    end else begin
      if (!power) begin
        forced_flag = 1'b1;
        r.sleep_set = 1'b1;
      end else if (!prev_power || forced_flag) begin
        forced_flag     = 1'b0;
        r.sleep_clear   = 1'b1;
        r.reset_request = 1'b1;
      end
      prev_power = power;
    end
    r.forced_off = forced_flag;
    return r;
  endfunction

  always @(posedge clk) begin
    status_beat_t got, want;
    if (rst) begin
      batt_min     = BATTERY_MIN_RESET;
      rail_min     = RAIL_MIN_RESET;
      seen_refresh = 1'b0;
      prev_power   = 1'b0;
      forced_flag  = 1'b0;
      n_bad        = 0;
      status_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BATTERY_MIN: batt_min = cfg_wdata;
          REG_RAIL_MIN:    rail_min = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        status_q.push_back(predict_status(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        got = status_beat_t'(m_tdata[6:0]);
        if (status_q.size() == 0) begin
          n_bad++;
          if (n_bad <= ReportMax)
            $display("%0t: status beat with nothing expected: %b", $time, m_tdata);
        end else begin
          want = status_q.pop_front();
          if (got.has_power !== want.has_power || got.usb_source !== want.usb_source
              || got.sleep_set !== want.sleep_set || got.sleep_clear !== want.sleep_clear
              || got.reset_request !== want.reset_request
              || got.forced_off !== want.forced_off) begin
            n_bad++;
            if (n_bad <= ReportMax)
              $display({"%0t: status mismatch exp pwr=%b src=%0d sset=%b sclr=%b rreq=%b ",
                        "foff=%b got pwr=%b src=%0d sset=%b sclr=%b rreq=%b foff=%b"},
                       $time, want.has_power, want.usb_source, want.sleep_set,
                       want.sleep_clear, want.reset_request, want.forced_off,
                       got.has_power, got.usb_source, got.sleep_set, got.sleep_clear,
                       got.reset_request, got.forced_off);
          end
        end
      end
      pending <= status_q.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Top of the power good supervisor bench: clock, reset, beat stimulus, config
// phases, receiver stalls, watchdog and verdict. Depends on pgs_pkg,
// power_good_supervisor and pgs_checker.
`timescale 1ns / 1ps

module tb_top;
  import pgs_pkg::*;

  localparam int IdleLimit     = 5000;  // cycles with no beat on either side
  localparam int PhaseItems    = 175;   // random beats per threshold setting
  localparam int SettleCycles  = 4;     // pipe is two deep; a little margin
  localparam int MaxGap        = 30;
  localparam int MaxBurst      = 60;

  logic                 clk;
  logic                 rst;
  logic [InDataW-1:0]   s_tdata;
  logic                 s_tuser;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [OutDataW-1:0]  m_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [RegW-1:0]      cfg_wdata;

  int chk_fails;
  int chk_pending;

  power_good_supervisor dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pgs_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (chk_fails),
    .pending    (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any accepted beat on either side restarts the count.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: switches between stall modes of random length, so there are
  // long stretches of full rate as well as heavy back pressure.
  int rx_mode = 0;
  int rx_left = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(5, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 9) != 0);
      default: m_tready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  // Sender state and current thresholds (used only to bias the readings)
  int burst_left = 0;
  int batt_cur   = 3300;
  int rail_cur   = 4500;

  // Last readings, reused now and then so the power state holds steady
  logic have_last = 1'b0;
  logic r_otg, r_cable, r_link;
  int   r_bus, r_dock, r_drail, r_bpres, r_bmv, r_braw;

  // One input beat, with the burst/gap pattern of the sender around it.
  task automatic drive_item(input logic op, input logic otg, input logic cable,
                            input int bus, input logic link, input int dock,
                            input int drail, input int bpres, input int bmv,
                            input int braw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MaxGap);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, MaxBurst);
    end
    s_tdata  <= {4'b0, braw[10:0], bmv[13:0], bpres[1:0], drail[13:0], dock[1:0],
                 link, bus[13:0], cable, otg};
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // Hold off the sender until every expected status beat has come out.
  task automatic settle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_thresholds(input int batt, input int rail);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BATTERY_MIN;
    cfg_wdata <= batt[RegW-1:0];
    @(posedge clk);
    cfg_index <= REG_RAIL_MIN;
    cfg_wdata <= rail[RegW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    batt_cur = batt;
    rail_cur = rail;
  endtask

  // Millivolt reading biased toward the threshold and the clamp edges.
  function automatic int pick_mv(int thr);
    int v;
    case ($urandom_range(0, 9))
      0:       v = -1;
      1:       v = 0;
      2:       v = 8191;
      3:       v = 5500;
      4:       v = 5501;
      5, 6:    v = thr - 1 + int'($urandom_range(0, 2));
      default: v = int'($urandom_range(0, 8191));
    endcase
    if (v > 8191) v = 8191;
    return v;
  endfunction

  // Raw ADC level; some near the level that maps onto the battery threshold.
  function automatic int pick_raw(int thr);
    int v;
    case ($urandom_range(0, 5))
      0:       v = -1;
      1:       v = 0;
      2:       v = int'($urandom_range(930, 1023));
      3:       v = (thr - 3000) * 31 / 40 - 2 + int'($urandom_range(0, 4));
      default: v = int'($urandom_range(0, 1023));
    endcase
    if (v < 0 && v != -1) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  task automatic random_item();
    logic op;
    if (!have_last || $urandom_range(0, 2) != 0) begin
      r_otg   = ($urandom_range(0, 5) == 0);
      r_cable = 1'($urandom_range(0, 1));
      r_bus   = pick_mv(rail_cur);
      r_link  = 1'($urandom_range(0, 1));
      r_dock  = int'($urandom_range(0, 2)) - 1;
      r_drail = pick_mv(rail_cur);
      r_bpres = int'($urandom_range(0, 2)) - 1;
      r_bmv   = ($urandom_range(0, 2) == 0) ? -1 : pick_mv(batt_cur);
      r_braw  = pick_raw(batt_cur);
      have_last = 1'b1;
    end
    op = ($urandom_range(0, 7) == 0) ? OP_BUTTON : OP_REFRESH;
    drive_item(op, r_otg, r_cable, r_bus, r_link, r_dock, r_drail, r_bpres,
               r_bmv, r_braw);
  endtask

  initial begin
    rst       <= 1'b1;
    s_tdata   <= '0;
    s_tuser   <= OP_REFRESH;
    s_tvalid  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_BATTERY_MIN;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats at the reset thresholds (3300 / 4500).
    // Button before any refresh: default battery 4200 mV gives power.
    drive_item(OP_BUTTON,  0, 0, -1,   0,  0,   -1, -1,   -1,   -1);
    // First refresh without power: records state, sets forced-off, sleeps.
    drive_item(OP_REFRESH, 0, 0, -1,   0,  0,   -1,  0,   -1,   -1);
    // Direct battery value exactly at threshold: power returns.
    drive_item(OP_REFRESH, 0, 0, -1,   0,  0,   -1,  1, 3300,   -1);
    drive_item(OP_REFRESH, 0, 0, -1,   0,  0,   -1,  1, 3299,   -1);
    // Raw ADC path: top of range, clamp, bottom, and the rounding edge.
    drive_item(OP_REFRESH, 0, 0, -1,   0,  0,   -1,  1,   -1,  930);
    drive_item(OP_REFRESH, 0, 0, -1,   0,  0,   -1,  1,   -1, 1023);
    drive_item(OP_REFRESH, 0, 0, -1,   0,  0,   -1,  1,   -1,    0);
    drive_item(OP_REFRESH, 0, 0, -1,   0,  0,   -1,  1,   -1,  232);
    drive_item(OP_REFRESH, 0, 0, -1,   0,  0,   -1,  1,   -1,  233);
    // OTG wins over a good bus but gives no external power.
    drive_item(OP_REFRESH, 1, 1, 8191, 1,  0,   -1,  0,   -1,   -1);
    // Cable with no bus reading.
    drive_item(OP_REFRESH, 0, 1, -1,   1,  0,   -1,  0,   -1,   -1);
    // Computer at threshold, then charger above the clamp.
    drive_item(OP_REFRESH, 0, 1, 4500, 1,  0,   -1,  0,   -1,   -1);
    drive_item(OP_REFRESH, 0, 1, 8191, 0,  0,   -1,  0,   -1,   -1);
    drive_item(OP_REFRESH, 0, 1, 4499, 1,  0,   -1,  0,   -1,   -1);
    drive_item(OP_REFRESH, 0, 1, 0,    0,  0,   -1,  0,   -1,   -1);
    // Dock rail paths.
    drive_item(OP_REFRESH, 0, 0, -1,   0,  1, 4500,  0,   -1,   -1);
    drive_item(OP_REFRESH, 0, 0, -1,   0, -1, 8191,  0,   -1,   -1);
    drive_item(OP_REFRESH, 0, 0, -1,   0,  1,   -1,  0,   -1,   -1);
    drive_item(OP_REFRESH, 0, 0, -1,   0,  1, 5501,  0,   -1,   -1);
    // Unset battery flag counts as present.
    drive_item(OP_REFRESH, 0, 0, -1,   0,  0,   -1, -1, 8191,   -1);
    // Buttons: no power, and a direct value that hides a good raw level.
    drive_item(OP_BUTTON,  0, 0, -1,   0,  0,   -1,  0,   -1,   -1);
    drive_item(OP_BUTTON,  0, 0, -1,   0,  0,   -1,  1,    0, 1023);
    drive_item(OP_BUTTON,  0, 1, 5500, 0,  0,   -1,  0,   -1,   -1);
    settle();

    // Random beats over several threshold settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_thresholds(3300, 4500);
        1: write_thresholds(0, 0);
        2: write_thresholds(8191, 8191);
        3: write_thresholds($urandom_range(2800, 4400), 5501);
        4: write_thresholds(4200, 5500);
        default: write_thresholds($urandom_range(0, 8191), $urandom_range(0, 8191));
      endcase
      for (int i = 0; i < PhaseItems; i++) random_item();
      settle();
    end

    repeat (10) @(posedge clk);
    if (chk_fails == 0 && chk_pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
src/pgs_pkg.sv
src/pgs_batt_level.sv
src/pgs_power_eval.sv
src/power_good_supervisor.sv
verif/pgs_checker.sv
verif/tb_top.sv
